// File: rtl/intel_hex_record_emitter_top_defines.svh
// Assertion helpers for the files that check their own logic.
// Each macro expects signals named clk and arst_n in the enclosing scope.
`ifndef INTEL_HEX_RECORD_EMITTER_TOP_DEFINES_SVH
`define INTEL_HEX_RECORD_EMITTER_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IHEX_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ihex check failed");

// Consequent must hold in the cycle after the antecedent.
`define IHEX_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ihex check failed");

`endif

// File: rtl/ihex_pkg.sv
`default_nettype none

package ihex_pkg;

	// Default number of data bytes per record.
	localparam int RecordBytesDef = 16;

	// Input actions.
	localparam logic ActData   = 1'b0;
	localparam logic ActFinish = 1'b1;

	// Fixed characters of the record text.
	localparam logic [7:0] ChColon = 8'h3A;
	localparam logic [7:0] ChCr    = 8'h0D;
	localparam logic [7:0] ChLf    = 8'h0A;

	// Record type bytes.
	localparam logic [7:0] TypeData = 8'h00;
	localparam logic [7:0] TypeEof  = 8'h01;

	typedef struct packed {
		logic       action;
		logic [7:0] data_byte;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] ascii_char;
		logic       last_char;
	} out_beat_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COLON,
		S_HEX_HI,
		S_HEX_LO,
		S_RD,
		S_CR,
		S_LF
	} state_t;

	// Which byte of the record is being printed.
	typedef enum logic [2:0] {
		F_COUNT,
		F_ADDR_HI,
		F_ADDR_LO,
		F_TYPE,
		F_DATA,
		F_CSUM
	} fld_t;

	// Which character source feeds the output register.
	typedef enum logic [2:0] {
		C_COLON,
		C_HI,
		C_LO,
		C_CR,
		C_LF
	} chr_t;

	typedef struct packed {
		logic wr;
		logic start_data;
		logic start_eof;
		logic emit;
		chr_t chr;
		fld_t fld;
		logic last;
		logic add_sum;
		logic next_idx;
	} ctl_cmd_t;

	typedef struct packed {
		logic full;
		logic fill_zero;
		logic count_zero;
		logic last_byte;
		logic out_free;
	} dp_sts_t;

	// Upper-case ASCII hex digit of a nibble.
	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		logic [7:0] c;
		if (nib < 4'd10) begin
			c = 8'h30 + {4'h0, nib};
		end else begin
			c = 8'h37 + {4'h0, nib};
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// File: rtl/ihex_ram.sv
`default_nettype none

module ihex_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/ihex_ctl.sv
`default_nettype none

module ihex_ctl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            action,
	input  wire ihex_pkg::dp_sts_t sts,
	output ihex_pkg::ctl_cmd_t   cmd,
	output logic                 in_stall
);

	import ihex_pkg::*;

	state_t state_q, state_d;
	fld_t   fld_q, fld_d;
	logic   pend_eof_q, pend_eof_d;
	logic   in_fire;

	assign in_fire  = in_valid && (state_q == S_IDLE);
	assign in_stall = (state_q != S_IDLE);

	// Next state: walk through the characters of one record, then of a pending end record.
	always_comb begin
		state_d    = state_q;
		fld_d      = fld_q;
		pend_eof_d = pend_eof_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					fld_d      = F_COUNT;
					pend_eof_d = (action == ActFinish) && !sts.fill_zero;
					if (action == ActFinish || sts.full) begin
						state_d = S_COLON;
					end
				end
			end
			S_COLON: begin
				if (sts.out_free) begin
					state_d = S_HEX_HI;
				end
			end
			S_HEX_HI: begin
				if (sts.out_free) begin
					state_d = S_HEX_LO;
				end
			end
			S_HEX_LO: begin
				if (sts.out_free) begin
					state_d = S_HEX_HI;
					case (fld_q)
						F_COUNT:   fld_d = F_ADDR_HI;
						F_ADDR_HI: fld_d = F_ADDR_LO;
						F_ADDR_LO: fld_d = F_TYPE;
						F_TYPE: begin
							if (sts.count_zero) begin
								fld_d = F_CSUM;
							end else begin
								fld_d   = F_DATA;
								state_d = S_RD;
							end
						end
						F_DATA: begin
							if (sts.last_byte) begin
								fld_d = F_CSUM;
							end else begin
								state_d = S_RD;
							end
						end
						F_CSUM:  state_d = S_CR;
						default: state_d = S_IDLE;
					endcase
				end
			end
			S_RD: begin
				state_d = S_HEX_HI;
			end
			S_CR: begin
				if (sts.out_free) begin
					state_d = S_LF;
				end
			end
			S_LF: begin
				if (sts.out_free) begin
					if (pend_eof_q) begin
						state_d    = S_COLON;
						fld_d      = F_COUNT;
						pend_eof_d = 1'b0;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Commands to the datapath.
	always_comb begin
		cmd            = '0;
		cmd.fld        = fld_q;
		cmd.chr        = C_COLON;
		cmd.wr         = in_fire && (action == ActData);
		cmd.start_data = in_fire && (((action == ActData) && sts.full) ||
			((action == ActFinish) && !sts.fill_zero));
		cmd.start_eof  = in_fire && (action == ActFinish) && sts.fill_zero;
		case (state_q)
			S_COLON: begin
				cmd.emit = sts.out_free;
				cmd.chr  = C_COLON;
			end
			S_HEX_HI: begin
				cmd.emit = sts.out_free;
				cmd.chr  = C_HI;
			end
			S_HEX_LO: begin
				cmd.emit     = sts.out_free;
				cmd.chr      = C_LO;
				cmd.add_sum  = sts.out_free && (fld_q != F_CSUM);
				cmd.next_idx = sts.out_free && (fld_q == F_DATA);
			end
			S_CR: begin
				cmd.emit = sts.out_free;
				cmd.chr  = C_CR;
			end
			S_LF: begin
				cmd.emit      = sts.out_free;
				cmd.chr       = C_LF;
				cmd.last      = !pend_eof_q;
				cmd.start_eof = sts.out_free && pend_eof_q;
			end
			default: begin
				cmd.emit = 1'b0;
			end
		endcase
	end

	// Controller registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			fld_q      <= F_COUNT;
			pend_eof_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			fld_q      <= fld_d;
			pend_eof_q <= pend_eof_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/ihex_dp.sv
`default_nettype none

module ihex_dp #(
	parameter int RECORD_BYTES = ihex_pkg::RecordBytesDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ihex_pkg::ctl_cmd_t cmd,
	output ihex_pkg::dp_sts_t       sts,
	input  wire logic [7:0]         data_byte,
	input  wire logic               cfg_we,
	input  wire logic [15:0]        cfg_data,
	input  wire logic               out_stall,
	output logic                    out_valid,
	output ihex_pkg::out_beat_t     out_data
);

	import ihex_pkg::*;

	localparam int CntW = $clog2(RECORD_BYTES + 1);
	localparam int AddrW = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

	logic [CntW-1:0] fill_q;
	logic [CntW-1:0] rec_count_q;
	logic [CntW-1:0] idx_q;
	logic [CntW-1:0] cnt_d;
	logic [15:0]     offset_q;
	logic [15:0]     start_q;
	logic [15:0]     rec_addr_q;
	logic            eof_rec_q;
	logic [7:0]      sum_q;
	logic [7:0]      rd_data;
	logic [7:0]      cur_byte;
	logic [7:0]      chr;
	logic            out_valid_q;
	out_beat_t       out_q;

	// Record buffer.
	ihex_ram #(
		.WIDTH(8),
		.DEPTH(RECORD_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (cmd.wr),
		.waddr(fill_q[AddrW-1:0]),
		.wdata(data_byte),
		.raddr(idx_q[AddrW-1:0]),
		.rdata(rd_data)
	);

	// Byte count of a data record started in this cycle.
	assign cnt_d = cmd.wr ? CntW'(fill_q + CntW'(1)) : fill_q;

	// Status back to the controller.
	always_comb begin
		sts.full       = (fill_q == CntW'(RECORD_BYTES - 1));
		sts.fill_zero  = (fill_q == '0);
		sts.count_zero = (rec_count_q == '0);
		sts.last_byte  = (CntW'(idx_q + CntW'(1)) == rec_count_q);
		sts.out_free   = !out_valid_q || !out_stall;
	end

	// Byte of the record currently being printed.
	always_comb begin
		case (cmd.fld)
			F_COUNT:   cur_byte = 8'(rec_count_q);
			F_ADDR_HI: cur_byte = rec_addr_q[15:8];
			F_ADDR_LO: cur_byte = rec_addr_q[7:0];
			F_TYPE:    cur_byte = eof_rec_q ? TypeEof : TypeData;
			F_DATA:    cur_byte = rd_data;
			F_CSUM:    cur_byte = 8'(~sum_q + 8'd1);
			default:   cur_byte = 8'h00;
		endcase
	end

	// Character to place in the output register.
	always_comb begin
		case (cmd.chr)
			C_COLON: chr = ChColon;
			C_HI:    chr = hex_char(cur_byte[7:4]);
			C_LO:    chr = hex_char(cur_byte[3:0]);
			C_CR:    chr = ChCr;
			C_LF:    chr = ChLf;
			default: chr = ChColon;
		endcase
	end

	// Fill count, running offset and start address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q   <= '0;
			offset_q <= '0;
			start_q  <= '0;
		end else begin
			if (cfg_we) begin
				start_q <= cfg_data;
			end
			if (cmd.start_data) begin
				fill_q   <= '0;
				offset_q <= offset_q + 16'(cnt_d);
			end else if (cmd.start_eof) begin
				fill_q   <= '0;
				offset_q <= '0;
			end else if (cmd.wr) begin
				fill_q <= cnt_d;
			end
		end
	end

	// Header fields, byte index and checksum of the record in flight.
	always_ff @(posedge clk) begin
		if (cmd.start_data) begin
			rec_count_q <= cnt_d;
			rec_addr_q  <= start_q + offset_q;
			eof_rec_q   <= 1'b0;
		end else if (cmd.start_eof) begin
			rec_count_q <= '0;
			rec_addr_q  <= '0;
			eof_rec_q   <= 1'b1;
		end
		if (cmd.start_data || cmd.start_eof) begin
			idx_q <= '0;
			sum_q <= '0;
		end else begin
			if (cmd.next_idx) begin
				idx_q <= CntW'(idx_q + CntW'(1));
			end
			if (cmd.add_sum) begin
				sum_q <= sum_q + cur_byte;
			end
		end
	end

	// Output register: one character beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.ascii_char <= chr;
			out_q.last_char  <= cmd.last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

`default_nettype wire

// File: rtl/intel_hex_record_emitter_top.sv
// Channel   Direction  Handshake            Beat
// in        input      in_valid / in_stall  action, data_byte
// out       output     out_valid / out_stall ascii_char, last_char
// cfg       input      cfg_valid / cfg_ready start_address (write only)
//
// A data byte that does not complete a record gives no beat. A record is sent one
// character per cycle while the output is not stalled, with a buffer read step
// before each data byte; the end record has no data bytes.
// Asynchronous active-low reset clears the fill count, offset and start address.
// A stalled output holds the sequencer; new input is taken only between records.
`default_nettype none

`include "intel_hex_record_emitter_top_defines.svh"

module intel_hex_record_emitter_top #(
	parameter int RECORD_BYTES = ihex_pkg::RecordBytesDef
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire ihex_pkg::in_beat_t  in_data,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output ihex_pkg::out_beat_t      out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [15:0]         cfg_data
);

	import ihex_pkg::*;

	ctl_cmd_t cmd;
	dp_sts_t  sts;

	// The start address register accepts a write in any cycle.
	assign cfg_ready = 1'b1;

	// Record sequencer.
	ihex_ctl u_ctl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.action  (in_data.action),
		.sts     (sts),
		.cmd     (cmd),
		.in_stall(in_stall)
	);

	// Buffer, counters, checksum and output register.
	ihex_dp #(
		.RECORD_BYTES(RECORD_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.data_byte(in_data.data_byte),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.out_data (out_data)
	);

	// A finish beat always produces at least the end record.
	`IHEX_ASSERT_NEXT(a_finish_busy, in_valid && !in_stall && in_data.action == ActFinish, in_stall)
	// A byte that does not fill the buffer leaves the block ready.
	`IHEX_ASSERT_NEXT(a_byte_quiet, in_valid && !in_stall && in_data.action == ActData && !sts.full, !in_stall)
	// After the final character of an item the block takes input again.
	`IHEX_ASSERT_NEXT(a_last_idle, cmd.emit && cmd.last, !in_stall)

endmodule

`default_nettype wire
